// ----- rtl/sbpd_pkg.sv -----
package sbpd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int PIXEL_W    = 8;
  localparam int CROSS_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int NUM_NB     = 8;
  localparam int BRANCH_LIMIT = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // neighbour ring as window row/column, starting top-left, going down the left side
  localparam logic [1:0] RING_R [NUM_NB] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0};
  localparam logic [1:0] RING_C [NUM_NB] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               center_set;
    logic [CROSS_W-1:0] crossings;
    logic               is_branch;
    logic               last_of_step;
    logic               frame_end;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } push_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr_a;
    logic [COL_W-1:0] addr_b;
  } lb_rd_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic             up;
    logic             mid;
  } lb_wr_t;

  typedef struct packed {
    logic up_a;
    logic mid_a;
    logic up_b;
    logic mid_b;
  } lb_data_t;

  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // grid bit r*3+c; rok/cok bit 0 = above/left, 1 = centre, 2 = below/right
  function automatic logic [CROSS_W-1:0] crossings_of(logic [8:0] g, logic [2:0] rok,
                                                      logic [2:0] cok);
    logic [CROSS_W-1:0] cnt;
    logic [3:0]         ia;
    logic [3:0]         ib;
    logic               oka;
    logic               okb;
    int                 m;
    cnt = '0;
    for (int n = 0; n < NUM_NB; n++) begin
      m   = (n + 1) % NUM_NB;
      ia  = 4'(RING_R[n]) * 4'd3 + 4'(RING_C[n]);
      ib  = 4'(RING_R[m]) * 4'd3 + 4'(RING_C[m]);
      oka = rok[RING_R[n]] && cok[RING_C[n]];
      okb = rok[RING_R[m]] && cok[RING_C[m]];
      if (oka && okb && !g[ia] && g[ib]) begin
        cnt = cnt + CROSS_W'(1);
      end
    end
    return cnt;
  endfunction

  function automatic res_t make_res(logic [8:0] g, logic [2:0] rok, logic [2:0] cok,
                                    logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                    logic last, logic fend);
    res_t r;
    r.row          = row;
    r.col          = col;
    r.center_set   = g[4];
    r.crossings    = crossings_of(g, rok, cok);
    r.is_branch    = g[4] && (r.crossings > CROSS_W'(BRANCH_LIMIT));
    r.last_of_step = last;
    r.frame_end    = fend;
    return r;
  endfunction

endpackage

// ----- rtl/sbpd_item_if.sv -----
interface sbpd_item_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [sbpd_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, kind, pixel, input ready);
  modport sink (input valid, kind, pixel, output ready);
endinterface

// ----- rtl/sbpd_result_if.sv -----
interface sbpd_result_if;
  logic                         valid;
  logic                         ready;
  logic [sbpd_pkg::ROW_W-1:0]   row;
  logic [sbpd_pkg::COL_W-1:0]   col;
  logic                         center_set;
  logic [sbpd_pkg::CROSS_W-1:0] crossings;
  logic                         is_branch;
  logic                         last_of_step;
  logic                         frame_end;

  modport source (output valid, row, col, center_set, crossings, is_branch, last_of_step,
                  frame_end, input ready);
  modport sink (input valid, row, col, center_set, crossings, is_branch, last_of_step,
                frame_end, output ready);
endinterface

// ----- rtl/sbpd_cfg_if.sv -----
interface sbpd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sbpd_pkg::CFG_IDX_W-1:0] index;
  logic [sbpd_pkg::DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/sbpd_line_buf.sv -----
module sbpd_line_buf (
  input  logic               clk,
  input  logic               rst,
  input  sbpd_pkg::lb_rd_t   rd,
  input  sbpd_pkg::lb_wr_t   wr,
  output sbpd_pkg::lb_data_t q,
  output logic               clearing
);
  import sbpd_pkg::*;

  logic             up_mem  [MAX_WIDTH];
  logic             mid_mem [MAX_WIDTH];
  logic [COL_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      up_mem[clr_addr]  <= 1'b0;
      mid_mem[clr_addr] <= 1'b0;
    end else if (wr.en) begin
      up_mem[wr.addr]  <= wr.up;
      mid_mem[wr.addr] <= wr.mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      q.up_a  <= up_mem[rd.addr_a];
      q.mid_a <= mid_mem[rd.addr_a];
      q.up_b  <= up_mem[rd.addr_b];
      q.mid_b <= mid_mem[rd.addr_b];
    end
  end

endmodule

// ----- rtl/sbpd_out_fifo.sv -----
module sbpd_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  sbpd_pkg::push_t push,
  output logic            room2,
  sbpd_result_if.source   result
);
  import sbpd_pkg::*;

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp;
  logic [FIFO_AW-1:0] rp;
  logic [FIFO_AW:0]   cnt;
  logic               pop;
  res_t               head;

  assign head  = mem[rp];
  assign pop   = result.valid && result.ready;
  assign room2 = cnt <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);

  assign result.valid        = cnt != '0;
  assign result.row          = head.row;
  assign result.col          = head.col;
  assign result.center_set   = head.center_set;
  assign result.crossings    = head.crossings;
  assign result.is_branch    = head.is_branch;
  assign result.last_of_step = head.last_of_step;
  assign result.frame_end    = head.frame_end;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wp] <= push.a;
    end
    if (push.n == 2'd2) begin
      mem[wp + FIFO_AW'(1)] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + FIFO_AW'(push.n);
      rp  <= rp + FIFO_AW'(pop);
      cnt <= cnt + (FIFO_AW + 1)'(push.n) - (FIFO_AW + 1)'(pop);
    end
  end

endmodule

// ----- rtl/skeleton_branch_point_detector.sv -----
// An accepted item is registered in stage s1, then its results enter the output FIFO.
// Throughput: one item per cycle when not held; a row-end pixel can yield two results.
// The first drain tick after a frame waits for the drain column window to load, longer
// when it directly follows a pixel; fewer than two free result slots stall a full s1.
// Reset: synchronous; clears control state, then a pass over all 1024 addresses zeroes
// both line buffers, while no item is taken (configuration writes are always taken).
module skeleton_branch_point_detector (
  input logic           clk,
  input logic           rst,
  sbpd_cfg_if.sink      cfg,
  sbpd_item_if.sink     item,
  sbpd_result_if.source result
);
  import sbpd_pkg::*;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_DRAIN = 2'd1,
    OP_PRIME = 2'd2
  } op_e;

  typedef struct packed {
    logic             vld;
    op_e              op;
    logic [COL_W-1:0] addr;
    logic             pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             emit_a;
    logic             emit_b;
    logic             up_ok;
    logic             left_a;
    logic             left_b;
    logic             right_ok;
    logic             fend;
    logic             fwd;
    logic             fwd_up;
    logic             fwd_mid;
  } s1_t;

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [DIM_W-1:0] drain_col;
  logic [DIM_W-1:0] dc_eff;
  logic [ROW_W-1:0] ir;
  logic [COL_W-1:0] ic;
  logic [COL_W-1:0] d;
  logic             last_col;
  logic             last_row;

  s1_t              s1;
  s1_t              s1_next;
  logic [8:0]       window;
  logic [8:0]       window_next;
  logic [1:0]       dwin_l;
  logic [1:0]       dwin_c;
  logic [1:0]       dwin_l_next;
  logic [1:0]       dwin_c_next;
  logic [COL_W:0]   dcen;
  logic [COL_W:0]   dcen_next;
  logic             dvalid;
  logic             dvalid_s1;

  logic             clearing;
  logic             room2;
  logic             adv;
  logic             go;
  logic             is_drain;
  logic             blk;
  logic             dmatch;
  logic             acc;
  logic             acc_pix;
  logic             acc_drn;
  logic             prime;

  lb_rd_t           rd;
  lb_wr_t           wr;
  lb_data_t         rdd;
  push_t            push;

  logic             up_eff;
  logic             mid_eff;
  logic [8:0]       nw;
  logic [8:0]       g2;
  logic [8:0]       dg;
  res_t             res_a;
  res_t             res_b;
  res_t             res_d;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
      endcase
    end
  end

  assign w = eff_dim(image_width, DIM_W'(MAX_WIDTH));
  assign h = eff_dim(image_height, DIM_W'(MAX_HEIGHT));

  // position, saturated to the current image size
  assign ir       = (DIM_W'(in_row) >= h) ? ROW_W'(h - DIM_W'(1)) : in_row;
  assign ic       = (DIM_W'(in_col) >= w) ? COL_W'(w - DIM_W'(1)) : in_col;
  assign last_col = DIM_W'(ic) == w - DIM_W'(1);
  assign last_row = DIM_W'(ir) == h - DIM_W'(1);
  assign dc_eff   = (drain_col > w) ? w : drain_col;
  assign d        = COL_W'(w - dc_eff);

  // input side control
  assign is_drain = item.kind == KIND_DRAIN;
  assign blk      = s1.vld && (s1.op == OP_PIXEL);
  assign adv      = !s1.vld || room2;
  assign dmatch   = dvalid_s1 && (dcen_next == {1'b0, d});

  assign item.ready = !clearing && adv &&
                      (!is_drain || (dc_eff == '0) || (dmatch && !blk));
  assign acc     = item.valid && item.ready;
  assign acc_pix = acc && !is_drain;
  assign acc_drn = acc && is_drain && (dc_eff != '0);
  assign prime   = !clearing && adv && item.valid && is_drain && (dc_eff != '0) &&
                   !dmatch && !blk && !(s1.vld && (s1.op == OP_PRIME));

  always_comb begin
    rd.en     = acc_pix || acc_drn || prime;
    rd.addr_b = d;
    if (acc_pix) begin
      rd.addr_a = ic;
    end else if (acc_drn) begin
      rd.addr_a = d + COL_W'(1);
    end else begin
      rd.addr_a = d - COL_W'(1);
    end
  end

  always_comb begin
    s1_next = s1;
    if (adv) begin
      s1_next     = '0;
      s1_next.op  = OP_PIXEL;
      s1_next.col = d;
      if (acc_pix) begin
        s1_next.vld     = 1'b1;
        s1_next.addr    = ic;
        s1_next.pix     = item.pixel != '0;
        s1_next.row     = ir - ROW_W'(1);
        s1_next.col     = ic;
        s1_next.emit_a  = (ir != '0) && (ic != '0);
        s1_next.emit_b  = (ir != '0) && last_col;
        s1_next.up_ok   = ir >= ROW_W'(2);
        s1_next.left_a  = ic >= COL_W'(2);
        s1_next.left_b  = ic != '0;
        s1_next.fwd     = blk && (s1.addr == ic);
        s1_next.fwd_up  = mid_eff;
        s1_next.fwd_mid = s1.pix;
      end else if (acc_drn) begin
        s1_next.vld      = 1'b1;
        s1_next.op       = OP_DRAIN;
        s1_next.row      = ROW_W'(h - DIM_W'(1));
        s1_next.up_ok    = h >= DIM_W'(2);
        s1_next.left_a   = d != '0;
        s1_next.right_ok = (DIM_W'(d) + DIM_W'(1)) < w;
        s1_next.fend     = DIM_W'(d) == w - DIM_W'(1);
      end else if (prime) begin
        s1_next.vld = 1'b1;
        s1_next.op  = OP_PRIME;
      end
    end
  end

  // result stage
  assign go      = s1.vld && room2;
  assign up_eff  = s1.fwd ? s1.fwd_up : rdd.up_a;
  assign mid_eff = s1.fwd ? s1.fwd_mid : rdd.mid_a;
  assign nw      = {s1.pix, window[8:7], mid_eff, window[5:4], up_eff, window[2:1]};
  assign g2      = {1'b0, nw[8:7], 1'b0, nw[5:4], 1'b0, nw[2:1]};
  assign dg      = {3'b000, rdd.mid_a, dwin_c[0], dwin_l[0], rdd.up_a, dwin_c[1], dwin_l[1]};

  assign res_a = make_res(nw, {2'b11, s1.up_ok}, {2'b11, s1.left_a}, s1.row,
                          s1.col - COL_W'(1), !s1.emit_b, 1'b0);
  assign res_b = make_res(g2, {2'b11, s1.up_ok}, {2'b01, s1.left_b}, s1.row, s1.col,
                          1'b1, 1'b0);
  assign res_d = make_res(dg, {2'b01, s1.up_ok}, {s1.right_ok, 1'b1, s1.left_a}, s1.row,
                          s1.col, 1'b1, s1.fend);

  always_comb begin
    push        = '0;
    window_next = window;
    dwin_l_next = dwin_l;
    dwin_c_next = dwin_c;
    dcen_next   = dcen;
    dvalid_s1   = dvalid;
    wr          = '0;
    if (go) begin
      case (s1.op)
        OP_PIXEL: begin
          window_next = nw;
          wr.en       = 1'b1;
          wr.addr     = s1.addr;
          wr.up       = mid_eff;
          wr.mid      = s1.pix;
          push.n      = {1'b0, s1.emit_a} + {1'b0, s1.emit_b};
          push.a      = s1.emit_a ? res_a : res_b;
          push.b      = res_b;
        end
        OP_DRAIN: begin
          push.n      = 2'd1;
          push.a      = res_d;
          dwin_l_next = dwin_c;
          dwin_c_next = {rdd.up_a, rdd.mid_a};
          dcen_next   = {1'b0, s1.col} + (COL_W + 1)'(1);
        end
        OP_PRIME: begin
          dwin_l_next = {rdd.up_a, rdd.mid_a};
          dwin_c_next = {rdd.up_b, rdd.mid_b};
          dcen_next   = {1'b0, s1.col};
          dvalid_s1   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld    <= 1'b0;
      in_row    <= '0;
      in_col    <= '0;
      drain_col <= '0;
      window    <= '0;
      dvalid    <= 1'b0;
      dcen      <= '0;
      dwin_l    <= '0;
      dwin_c    <= '0;
    end else begin
      s1     <= s1_next;
      window <= window_next;
      dwin_l <= dwin_l_next;
      dwin_c <= dwin_c_next;
      dcen   <= dcen_next;
      dvalid <= acc_pix ? 1'b0 : dvalid_s1;
      if (acc_pix) begin
        drain_col <= '0;
        in_row    <= ir;
        if (last_col) begin
          in_col <= '0;
          if (last_row) begin
            in_row    <= '0;
            drain_col <= w;
          end else begin
            in_row <= ir + ROW_W'(1);
          end
        end else begin
          in_col <= ic + COL_W'(1);
        end
      end else if (acc) begin
        drain_col <= dc_eff - DIM_W'(dc_eff != '0);
      end
    end
  end

  sbpd_line_buf u_line_buf (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .wr       (wr),
    .q        (rdd),
    .clearing (clearing)
  );

  sbpd_out_fifo u_out_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room2  (room2),
    .result (result)
  );

endmodule

// ----- tb/sv/skeleton_branch_point_detector_test.sv -----
`timescale 1ns / 1ps

module skeleton_branch_point_detector_test;
  import sbpd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 520;
  // window bit positions going round the neighbours, top-left first, down the left side
  localparam int RING_POS [NUM_NB] = '{0, 3, 6, 7, 8, 5, 2, 1};
  localparam logic [PIXEL_W-1:0] T_SHAPE [9] = '{8'hFF, 8'h00, 8'h01,
                                                 8'h00, 8'h80, 8'h00,
                                                 8'h00, 8'h7E, 8'h00};
  localparam logic [PIXEL_W-1:0] SHORT_ROWS [6] = '{8'h55, 8'hAA, 8'h00,
                                                    8'hFF, 8'h01, 8'h80};

  class crossing_scoreboard;
    bit               upper_px [MAX_WIDTH];
    bit               middle_px [MAX_WIDTH];
    bit [8:0]         win;
    int unsigned      next_row;
    int unsigned      next_col;
    int unsigned      drain_left;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    res_t             awaited [$];
    int               errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      errors     = 0;
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned top);
      if (v == '0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function int unsigned cols();
      return clamp_dim(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned rows();
      return clamp_dim(height_reg, MAX_HEIGHT);
    endfunction

    function void write_reg(cfg_reg_e idx, logic [DIM_W-1:0] v);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = v;
      end else begin
        height_reg = v;
      end
    endfunction

    function bit [CROSS_W-1:0] crossing_count(bit [8:0] g, bit [2:0] rok, bit [2:0] cok);
      bit [CROSS_W-1:0] cnt;
      int               a;
      int               b;
      cnt = '0;
      for (int n = 0; n < NUM_NB; n++) begin
        a = RING_POS[n];
        b = RING_POS[(n + 1) % NUM_NB];
        if (rok[a / 3] && cok[a % 3] && rok[b / 3] && cok[b % 3] && !g[a] && g[b]) begin
          cnt++;
        end
      end
      return cnt;
    endfunction

    function void add_point(int unsigned row, int unsigned col, bit [8:0] g, bit [2:0] rok,
                            bit [2:0] cok, bit fend);
      res_t r;
      r.row          = ROW_W'(row);
      r.col          = COL_W'(col);
      r.center_set   = g[4];
      r.crossings    = crossing_count(g, rok, cok);
      r.is_branch    = g[4] && r.crossings > BRANCH_LIMIT;
      r.last_of_step = 1'b0;
      r.frame_end    = fend;
      awaited.insert(awaited.size(), r);
    endfunction

    function void predict_item(logic kind, logic [PIXEL_W-1:0] px);
      int unsigned w;
      int unsigned h;
      int unsigned ir;
      int unsigned ic;
      int unsigned d;
      int          start;
      bit [2:0]    rok;
      bit [2:0]    cok;
      bit [2:0]    col_in;
      bit [8:0]    g;
      res_t        r;
      w     = cols();
      h     = rows();
      start = awaited.size();
      if (kind == KIND_DRAIN) begin
        if (drain_left > w) drain_left = w;
        if (drain_left == 0) return;
        d   = w - drain_left;
        g   = '0;
        cok = '0;
        for (int dc = 0; dc < 3; dc++) begin
          if (d + dc >= 1 && d + dc <= w) begin
            cok[dc]   = 1'b1;
            g[dc]     = upper_px[d + dc - 1];
            g[3 + dc] = middle_px[d + dc - 1];
          end
        end
        rok = {1'b0, 1'b1, h >= 2};
        add_point(h - 1, d, g, rok, cok, d == w - 1);
        drain_left--;
      end else begin
        drain_left = 0;
        ir = (next_row < h) ? next_row : h - 1;
        ic = (next_col < w) ? next_col : w - 1;
        col_in = {px != 0, middle_px[ic], upper_px[ic]};
        upper_px[ic]  = middle_px[ic];
        middle_px[ic] = px != 0;
        for (int r3 = 0; r3 < 3; r3++) begin
          win[3 * r3 +: 3] = {col_in[r3], win[3 * r3 + 2], win[3 * r3 + 1]};
        end
        if (ir >= 1) begin
          rok = {1'b1, 1'b1, ir >= 2};
          if (ic >= 1) add_point(ir - 1, ic - 1, win, rok, {1'b1, 1'b1, ic >= 2}, 1'b0);
          if (ic == w - 1) begin
            g = '0;
            for (int r3 = 0; r3 < 3; r3++) begin
              g[3 * r3 +: 3] = {1'b0, win[3 * r3 + 2], win[3 * r3 + 1]};
            end
            add_point(ir - 1, ic, g, rok, {1'b0, 1'b1, ic >= 1}, 1'b0);
          end
        end
        if (ic + 1 >= w) begin
          ic = 0;
          if (ir + 1 >= h) begin
            ir = 0;
            drain_left = w;
          end else begin
            ir++;
          end
        end else begin
          ic++;
        end
        next_row = ir;
        next_col = ic;
      end
      if (awaited.size() > start) begin
        r = awaited.pop_back();
        r.last_of_step = 1'b1;
        awaited.insert(awaited.size(), r);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: row %0d col %0d", got.row, got.col);
        return;
      end
      want = awaited.pop_front();
      if (got.row !== want.row || got.col !== want.col ||
          got.center_set !== want.center_set || got.crossings !== want.crossings ||
          got.is_branch !== want.is_branch || got.last_of_step !== want.last_of_step ||
          got.frame_end !== want.frame_end) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp row %0d col %0d set %0b cross %0d br %0b last %0b end %0b",
                   want.row, want.col, want.center_set, want.crossings, want.is_branch,
                   want.last_of_step, want.frame_end);
          $display("          act row %0d col %0d set %0b cross %0d br %0b last %0b end %0b",
                   got.row, got.col, got.center_set, got.crossings, got.is_branch,
                   got.last_of_step, got.frame_end);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned cycles = 0;
  int unsigned stim_count = 0;
  int unsigned result_hold = 0;
  bit          item_calm = 1'b0;
  bit          result_calm = 1'b0;

  sbpd_cfg_if    cfg_ch ();
  sbpd_item_if   item_ch ();
  sbpd_result_if result_ch ();

  skeleton_branch_point_detector uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  crossing_scoreboard board = new();

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    return $urandom_range(0, 1) ? PIXEL_W'($urandom_range(1, 255)) : '0;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return DIM_W'(MAX_WIDTH + $urandom_range(0, 1));
      3: return DIM_W'($urandom_range(0, 2047));
      default: return DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  // results checked before the same edge's input is predicted
  always @(posedge clk) begin
    res_t got;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.row          = result_ch.row;
        got.col          = result_ch.col;
        got.center_set   = result_ch.center_set;
        got.crossings    = result_ch.crossings;
        got.is_branch    = result_ch.is_branch;
        got.last_of_step = result_ch.last_of_step;
        got.frame_end    = result_ch.frame_end;
        board.check_result(got);
      end
      if (item_ch.valid && item_ch.ready) board.predict_item(item_ch.kind, item_ch.pixel);
      if (cfg_ch.valid && cfg_ch.ready) board.write_reg(cfg_reg_e'(cfg_ch.index), cfg_ch.data);
    end
  end

  always @(posedge clk) begin
    int unsigned stall;
    if (rst) begin
      result_ch.ready <= 1'b0;
      result_hold     <= 0;
    end else if (result_ch.valid && result_ch.ready) begin
      if ($urandom_range(0, 63) == 0) result_calm = ~result_calm;
      stall = draw_wait(result_calm);
      result_ch.ready <= (stall == 0);
      result_hold     <= stall;
    end else if (!result_ch.ready) begin
      if (result_hold <= 1) begin
        result_ch.ready <= 1'b1;
        result_hold     <= 0;
      end else begin
        result_hold <= result_hold - 1;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [PIXEL_W-1:0] px);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) item_calm = ~item_calm;
    gap = draw_wait(item_calm);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind  <= kind;
    item_ch.pixel <= px;
    do @(posedge clk); while (!item_ch.ready);
    stim_count++;
  endtask

  // wait for every expected result, then for the pipeline to empty
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_e idx, input logic [DIM_W-1:0] v);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned random_end;
    int unsigned w;
    int unsigned h;
    int unsigned ir;
    int unsigned ic;
    int unsigned n;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_IMAGE_WIDTH;
    cfg_ch.data     <= '0;
    item_ch.valid   <= 1'b0;
    item_ch.kind    <= KIND_PIXEL;
    item_ch.pixel   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // T junction in a 3x3 image, full drain plus one spare tick
    set_reg(REG_IMAGE_WIDTH, DIM_W'(3));
    set_reg(REG_IMAGE_HEIGHT, DIM_W'(3));
    foreach (T_SHAPE[i]) send_item(KIND_PIXEL, T_SHAPE[i]);
    repeat (4) send_item(KIND_DRAIN, '0);

    // zero sizes act as a single pixel
    set_reg(REG_IMAGE_WIDTH, '0);
    set_reg(REG_IMAGE_HEIGHT, '0);
    send_item(KIND_PIXEL, 8'hFF);
    send_item(KIND_DRAIN, 8'hFF);

    // width shrunk while the last row waits: pending count is cut
    set_reg(REG_IMAGE_WIDTH, DIM_W'(3));
    set_reg(REG_IMAGE_HEIGHT, DIM_W'(2));
    foreach (SHORT_ROWS[i]) send_item(KIND_PIXEL, SHORT_ROWS[i]);
    set_reg(REG_IMAGE_WIDTH, DIM_W'(2));
    repeat (3) send_item(KIND_DRAIN, '0);

    // widest row, then tallest column, each left part-way through the frame
    set_reg(REG_IMAGE_WIDTH, '1);
    set_reg(REG_IMAGE_HEIGHT, DIM_W'(1));
    repeat (24) send_item(KIND_PIXEL, rand_pixel());
    set_reg(REG_IMAGE_WIDTH, DIM_W'(1));
    set_reg(REG_IMAGE_HEIGHT, '1);
    repeat (24) send_item(KIND_PIXEL, rand_pixel());
    repeat (2) send_item(KIND_DRAIN, '0);

    random_end = stim_count + RANDOM_ITEMS;
    while (stim_count < random_end) begin
      case ($urandom_range(0, 9))
        0: set_reg(cfg_reg_e'($urandom_range(0, 1)), pick_dim());
        1: begin
          n = $urandom_range(1, 6);
          repeat (n) begin
            send_item($urandom_range(0, 3) == 0 ? KIND_DRAIN : KIND_PIXEL,
                      PIXEL_W'($urandom()));
          end
        end
        default: begin
          if ($urandom_range(0, 2) == 0 || board.cols() * board.rows() > 64) begin
            set_reg(REG_IMAGE_WIDTH, DIM_W'($urandom_range(1, 8)));
            set_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(1, 6)));
          end
          // idle the input so the position below is up to date
          item_ch.valid <= 1'b0;
          @(posedge clk);
          w  = board.cols();
          h  = board.rows();
          ir = (board.next_row < h) ? board.next_row : h - 1;
          ic = (board.next_col < w) ? board.next_col : w - 1;
          n  = w * h - ir * w - ic;
          repeat (n) send_item(KIND_PIXEL, rand_pixel());
          case ($urandom_range(0, 5))
            0: n = $urandom_range(0, w - 1);
            1: n = w + $urandom_range(1, 3);
            default: n = w;
          endcase
          repeat (n) send_item(KIND_DRAIN, PIXEL_W'($urandom()));
        end
      endcase
    end

    settle();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
